[hw/rtl/tra_pkg.sv]
`timescale 1ns / 1ps

package tra_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int MODE_W  = 2;
  localparam int TIME_W  = 48;
  localparam int PRICE_W = 32;
  localparam int VOL_W   = 32;
  localparam int SUM_W   = 48;

  // command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_STORE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [TIME_W-1:0]  tick_time;
    logic [PRICE_W-1:0] tick_price;
    logic [VOL_W-1:0]   tick_volume;
    logic [TIME_W-1:0]  window_length;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] fill;
  } bk_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_WALK = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  function automatic logic [ADDR_W-1:0] ring_prev(input logic [ADDR_W-1:0] a);
    return (a == '0) ? ADDR_W'(DEPTH - 1) : a - 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [QPTR_W-1:0] q_next(input logic [QPTR_W-1:0] a);
    return (a == QPTR_W'(QDEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

endpackage

[hw/rtl/tra_front.sv]
`timescale 1ns / 1ps

module tra_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tra_pkg::MODE_W-1:0]  in_mode,
  input  logic [tra_pkg::TIME_W-1:0]  in_tick_time,
  input  logic [tra_pkg::PRICE_W-1:0] in_tick_price,
  input  logic [tra_pkg::VOL_W-1:0]   in_tick_volume,
  input  logic [tra_pkg::TIME_W-1:0]  in_window_length,
  output tra_pkg::cmd_t               q_cmd,
  output logic                        q_valid,
  input  logic                        q_pop
);
  import tra_pkg::*;

  cmd_t              queue_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              known_op;
  logic              push;
  cmd_t              cmd_in;

  // classify the incoming transaction; the unused mode is taken and dropped
  always_comb begin
    cmd_in.tick_time     = in_tick_time;
    cmd_in.tick_price    = in_tick_price;
    cmd_in.tick_volume   = in_tick_volume;
    cmd_in.window_length = in_window_length;
    case (in_mode)
      MODE_STORE: begin
        cmd_in.op = OP_STORE;
        known_op  = 1'b1;
      end
      MODE_QUERY: begin
        cmd_in.op = OP_QUERY;
        known_op  = 1'b1;
      end
      MODE_CLEAR: begin
        cmd_in.op = OP_CLEAR;
        known_op  = 1'b1;
      end
      default: begin
        cmd_in.op = OP_STORE;
        known_op  = 1'b0;
      end
    endcase
  end

  assign in_stall = (count_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall && known_op;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? q_next(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? q_next(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

[hw/rtl/tra_back.sv]
`timescale 1ns / 1ps

module tra_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tra_pkg::cmd_t               q_cmd,
  input  logic                        q_valid,
  output logic                        q_pop,
  output tra_pkg::bk_stat_t           stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tra_pkg::PRICE_W-1:0] out_open_price,
  output logic [tra_pkg::PRICE_W-1:0] out_high_price,
  output logic [tra_pkg::PRICE_W-1:0] out_low_price,
  output logic [tra_pkg::PRICE_W-1:0] out_close_price,
  output logic [tra_pkg::SUM_W-1:0]   out_volume_sum,
  output logic [tra_pkg::CNT_W-1:0]   out_stored_count
);
  import tra_pkg::*;

  logic [TIME_W-1:0]  time_mem  [DEPTH];
  logic [PRICE_W-1:0] price_mem [DEPTH];
  logic [VOL_W-1:0]   vol_mem   [DEPTH];

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  wp_r, wp_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [ADDR_W-1:0]  rd_addr, rd_ptr_r;
  logic [TIME_W-1:0]  rd_time_r;
  logic [PRICE_W-1:0] rd_price_r;
  logic [VOL_W-1:0]   rd_vol_r;

  logic [CNT_W-1:0]   back_r;
  logic [TIME_W-1:0]  window_r, now_r;
  logic [PRICE_W-1:0] open_r, high_r, low_r, close_r;
  logic [SUM_W-1:0]   vol_r;
  logic [PRICE_W-1:0] out_open_r, out_high_r, out_low_r, out_close_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic [CNT_W-1:0]   out_count_r;

  logic               wr_en, take_query, in_window, walk_done, out_load;
  logic [SUM_W:0]     vol_add;
  logic [SUM_W-1:0]   vol_sat;

  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign wr_en      = q_pop && (q_cmd.op == OP_STORE);
  assign take_query = q_pop && (q_cmd.op == OP_QUERY);

  // walk runs from the newest slot backwards, one read issued per cycle
  assign rd_addr = (state_r == ST_IDLE) ? ring_prev(wp_r) : ring_prev(rd_ptr_r);

  assign in_window = ({1'b0, rd_time_r} + {1'b0, window_r}) >= {1'b0, now_r};
  assign walk_done = (back_r == fill_r) || !in_window;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  assign vol_add = {1'b0, vol_r} + (SUM_W + 1)'(rd_vol_r);
  assign vol_sat = vol_add[SUM_W] ? {SUM_W{1'b1}} : vol_add[SUM_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_cmd.op)
            OP_STORE: begin
              wp_nxt = ring_next(wp_r);
              if (fill_r != CNT_W'(DEPTH)) begin
                fill_nxt = fill_r + 1'b1;
              end
            end
            OP_QUERY: begin
              state_nxt = (fill_r == '0) ? ST_OUT : ST_HEAD;
            end
            OP_CLEAR: begin
              wp_nxt   = '0;
              fill_nxt = '0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_HEAD: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wp_r] <= q_cmd.tick_time;
    end
    rd_time_r <= time_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      price_mem[wp_r] <= q_cmd.tick_price;
    end
    rd_price_r <= price_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vol_mem[wp_r] <= q_cmd.tick_volume;
    end
    rd_vol_r <= vol_mem[rd_addr];
  end

  // accumulators for the window walk
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_addr;
    if (take_query) begin
      window_r <= q_cmd.window_length;
      open_r   <= '0;
      high_r   <= '0;
      low_r    <= '0;
      close_r  <= '0;
      vol_r    <= '0;
    end
    if (state_r == ST_HEAD) begin
      // newest tick is always inside its own window
      now_r   <= rd_time_r;
      open_r  <= rd_price_r;
      high_r  <= rd_price_r;
      low_r   <= rd_price_r;
      close_r <= rd_price_r;
      vol_r   <= SUM_W'(rd_vol_r);
      back_r  <= CNT_W'(1);
    end
    if ((state_r == ST_WALK) && !walk_done) begin
      open_r <= rd_price_r;
      if (rd_price_r > high_r) begin
        high_r <= rd_price_r;
      end
      if (rd_price_r < low_r) begin
        low_r <= rd_price_r;
      end
      vol_r  <= vol_sat;
      back_r <= back_r + 1'b1;
    end
    if (out_load) begin
      out_open_r  <= open_r;
      out_high_r  <= high_r;
      out_low_r   <= low_r;
      out_close_r <= close_r;
      out_sum_r   <= vol_r;
      out_count_r <= fill_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_open_price   = out_open_r;
  assign out_high_price   = out_high_r;
  assign out_low_price    = out_low_r;
  assign out_close_price  = out_close_r;
  assign out_volume_sum   = out_sum_r;
  assign out_stored_count = out_count_r;

  assign stat.busy = (state_r != ST_IDLE);
  assign stat.fill = fill_r;

endmodule

[hw/rtl/tick_ring_ohlcv_aggregator.sv]
// Tick ring with OHLCV window queries.
// Input channel (in_valid / in_stall) carries one command per transaction:
// mode 0 stores a tick, mode 1 asks for open/high/low/close and summed volume
// over the window and for the stored count, mode 2 empties the ring, mode 3 is
// taken and ignored. Only mode 1 produces a transaction on the output channel
// (out_valid / out_stall).
// A two-entry command queue sits in front of the ring logic, so stores and
// clears go through at one per cycle and in_stall only rises while a query
// holds the back end.
// A query walks the ring from the newest tick, one memory read per cycle, through
// the pop, first-read (ST_HEAD), walk and output-load steps; an empty ring goes
// straight from the pop to the output load.
// The result sits in an output register; while out_stall is high the query
// waits there and further commands pile up in the queue, then stall the input.
// Reset (synchronous, rst_n low) empties the ring and the queue; stored tick
// contents are not cleared and are never read before they are written.
`timescale 1ns / 1ps

module tick_ring_ohlcv_aggregator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tra_pkg::MODE_W-1:0]  in_mode,
  input  logic [tra_pkg::TIME_W-1:0]  in_tick_time,
  input  logic [tra_pkg::PRICE_W-1:0] in_tick_price,
  input  logic [tra_pkg::VOL_W-1:0]   in_tick_volume,
  input  logic [tra_pkg::TIME_W-1:0]  in_window_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tra_pkg::PRICE_W-1:0] out_open_price,
  output logic [tra_pkg::PRICE_W-1:0] out_high_price,
  output logic [tra_pkg::PRICE_W-1:0] out_low_price,
  output logic [tra_pkg::PRICE_W-1:0] out_close_price,
  output logic [tra_pkg::SUM_W-1:0]   out_volume_sum,
  output logic [tra_pkg::CNT_W-1:0]   out_stored_count
);
  import tra_pkg::*;

  cmd_t     q_cmd;
  logic     q_valid;
  logic     q_pop;
  bk_stat_t stat;

  tra_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_tick_time     (in_tick_time),
    .in_tick_price    (in_tick_price),
    .in_tick_volume   (in_tick_volume),
    .in_window_length (in_window_length),
    .q_cmd            (q_cmd),
    .q_valid          (q_valid),
    .q_pop            (q_pop)
  );

  tra_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_cmd            (q_cmd),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_open_price   (out_open_price),
    .out_high_price   (out_high_price),
    .out_low_price    (out_low_price),
    .out_close_price  (out_close_price),
    .out_volume_sum   (out_volume_sum),
    .out_stored_count (out_stored_count)
  );

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= CNT_W'(DEPTH))
    else $error("ring fill count above depth");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !q_pop)
    else $error("command taken while a query is running");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.busy))
    else $error("result without a query in progress");

endmodule

[dv/tb_tick_ring_ohlcv_aggregator.sv]
`timescale 1ns / 1ps

module tb_tick_ring_ohlcv_aggregator;
  import tra_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 8;
  localparam int N_DIR          = 23;
  localparam int RAND_PER_PHASE = 130;
  localparam int FILL_RUN       = 400;
  localparam int GAP_ALLOW      = 40;
  localparam int STALL_ALLOW    = 40;
  localparam int WATCH_SLACK    = 20000;
  localparam int DRAIN_CYCLES   = DEPTH + 16;

  localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0]  T_MAX       = '1;
  localparam logic [PRICE_W-1:0] P_MAX       = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX     = '1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [TIME_W-1:0]  tick_time;
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
    logic [TIME_W-1:0]  window;
  } tick_cmd_t;

  typedef struct packed {
    logic [PRICE_W-1:0] open_px;
    logic [PRICE_W-1:0] high_px;
    logic [PRICE_W-1:0] low_px;
    logic [PRICE_W-1:0] close_px;
    logic [SUM_W-1:0]   vol_sum;
    logic [CNT_W-1:0]   count;
  } bar_t;

  typedef struct packed {
    tick_cmd_t cmd;
    logic      fixed;
    bar_t      bar;
  } dir_row_t;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode          = '0;
  logic [TIME_W-1:0]   in_tick_time     = '0;
  logic [PRICE_W-1:0]  in_tick_price    = '0;
  logic [VOL_W-1:0]    in_tick_volume   = '0;
  logic [TIME_W-1:0]   in_window_length = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [PRICE_W-1:0]  out_open_price;
  logic [PRICE_W-1:0]  out_high_price;
  logic [PRICE_W-1:0]  out_low_price;
  logic [PRICE_W-1:0]  out_close_price;
  logic [SUM_W-1:0]    out_volume_sum;
  logic [CNT_W-1:0]    out_stored_count;

  // shadow copy of the tick ring
  logic [TIME_W-1:0]  ring_time  [DEPTH];
  logic [PRICE_W-1:0] ring_price [DEPTH];
  logic [VOL_W-1:0]   ring_vol   [DEPTH];
  int                 wr_ptr = 0;
  int                 fill   = 0;

  bar_t               expected_bars [$];
  dir_row_t           dir_table [N_DIR];
  logic [TIME_W-1:0]  last_time  = '0;
  logic [PRICE_W-1:0] last_price = '0;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 error_count    = 0;
  longint             cycle_count    = 0;
  longint             cycle_budget   = 0;

  tick_ring_ohlcv_aggregator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_tick_time     (in_tick_time),
    .in_tick_price    (in_tick_price),
    .in_tick_volume   (in_tick_volume),
    .in_window_length (in_window_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_open_price   (out_open_price),
    .out_high_price   (out_high_price),
    .out_low_price    (out_low_price),
    .out_close_price  (out_close_price),
    .out_volume_sum   (out_volume_sum),
    .out_stored_count (out_stored_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int back_slot(input int back);
    return (wr_ptr + DEPTH - 1 - back) % DEPTH;
  endfunction

  function automatic logic [TIME_W-1:0] rand48();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // updates the shadow ring and works out the bar a query returns
  function automatic void apply_command(input tick_cmd_t c, output logic has_bar,
                                        output bar_t bar);
    int                 slot;
    int                 i;
    logic               walking;
    logic [TIME_W-1:0]  now;
    logic [SUM_W:0]     acc;
    logic [PRICE_W-1:0] p;
    has_bar = 1'b0;
    bar = '0;
    case (c.mode)
      MODE_STORE: begin
        ring_time[wr_ptr]  = c.tick_time;
        ring_price[wr_ptr] = c.price;
        ring_vol[wr_ptr]   = c.volume;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (fill < DEPTH) fill++;
      end
      MODE_QUERY: begin
        has_bar = 1'b1;
        if (fill != 0) begin
          slot = back_slot(0);
          now = ring_time[slot];
          bar.close_px = ring_price[slot];
          bar.open_px  = bar.close_px;
          bar.high_px  = bar.close_px;
          bar.low_px   = bar.close_px;
          acc = '0;
          i = 0;
          walking = 1'b1;
          while (walking && i < fill) begin
            slot = back_slot(i);
            // 49-bit compare, time + window may carry out of 48 bits
            if ({1'b0, ring_time[slot]} + {1'b0, c.window} < {1'b0, now}) begin
              walking = 1'b0;
            end else begin
              p = ring_price[slot];
              bar.open_px = p;
              if (p > bar.high_px) bar.high_px = p;
              if (p < bar.low_px) bar.low_px = p;
              acc = acc + (SUM_W + 1)'(ring_vol[slot]);
              if (acc > {1'b0, SUM_MAX}) acc = {1'b0, SUM_MAX};
              i++;
            end
          end
          bar.vol_sum = acc[SUM_W-1:0];
          bar.count = CNT_W'(fill);
        end
      end
      MODE_CLEAR: begin
        wr_ptr = 0;
        fill = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic tick_cmd_t make_command();
    tick_cmd_t         c;
    int                r;
    int                k;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] t_k;
    // unused fields carry noise
    c.mode      = MODE_UNUSED;
    c.tick_time = rand48();
    c.price     = $urandom();
    c.volume    = $urandom();
    c.window    = rand48();
    r = $urandom_range(0, 99);
    if (r < 62) begin
      c.mode = MODE_STORE;
      r = $urandom_range(0, 99);
      if (r < 4) last_time = rand48();
      else if (r < 8) last_time = last_time - TIME_W'($urandom_range(1, 500));
      else last_time = last_time + TIME_W'($urandom_range(0, 300));
      c.tick_time = last_time;
      r = $urandom_range(0, 99);
      if (r < 30) last_price = $urandom();
      else last_price = last_price + PRICE_W'($urandom_range(0, 2000)) - PRICE_W'(1000);
      c.price = last_price;
      r = $urandom_range(0, 99);
      if (r < 25) c.volume = $urandom_range(0, 1000);
      else if (r < 28) c.volume = P_MAX;
    end else if (r < 90) begin
      c.mode = MODE_QUERY;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        c.window = '0;
      end else if (r < 15) begin
        c.window = T_MAX;
      end else if (r >= 25) begin
        c.window = TIME_W'($urandom_range(0, 500));
        if (fill > 0) begin
          // put the window edge on or just past a stored tick
          k = $urandom_range(0, fill - 1);
          now = ring_time[back_slot(0)];
          t_k = ring_time[back_slot(k)];
          if (t_k <= now)
            c.window = now - t_k -
                       TIME_W'((now != t_k && $urandom_range(0, 1)) ? 1 : 0);
        end
      end
    end else if (r < 94) begin
      c.mode = MODE_CLEAR;
    end
    return c;
  endfunction

  task automatic push_command(input tick_cmd_t c, input logic use_fixed,
                              input bar_t fixed_bar);
    logic has_bar;
    bar_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cycle_budget += GAP_ALLOW + ((c.mode == MODE_QUERY) ? fill + 3 + STALL_ALLOW : 1);
    in_valid         <= 1'b1;
    in_mode          <= c.mode;
    in_tick_time     <= c.tick_time;
    in_tick_price    <= c.price;
    in_tick_volume   <= c.volume;
    in_window_length <= c.window;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_command(c, has_bar, pred);
    if (has_bar) expected_bars.insert(expected_bars.size(), use_fixed ? fixed_bar : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bars.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [SUM_W-1:0] want,
                                      input logic [SUM_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    bar_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bars.size() == 0) begin
        $error("result transaction with no query outstanding");
        error_count++;
      end else begin
        want = expected_bars.pop_front();
        check_field("open_price", SUM_W'(want.open_px), SUM_W'(out_open_price));
        check_field("high_price", SUM_W'(want.high_px), SUM_W'(out_high_price));
        check_field("low_price", SUM_W'(want.low_px), SUM_W'(out_low_price));
        check_field("close_price", SUM_W'(want.close_px), SUM_W'(out_close_price));
        check_field("volume_sum", want.vol_sum, out_volume_sum);
        check_field("stored_count", SUM_W'(want.count), SUM_W'(out_stored_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > WATCH_SLACK + 4 * cycle_budget) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    tick_cmd_t c;
    int        taken;

    // empty ring and unused mode
    dir_table[0]  = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, 48'd0}, 1'b1, '0};
    dir_table[1]  = '{'{MODE_UNUSED, T_MAX, P_MAX, P_MAX, T_MAX}, 1'b0, '0};
    dir_table[2]  = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, T_MAX}, 1'b1, '0};
    // price and volume extremes on one timestamp
    dir_table[3]  = '{'{MODE_STORE, 48'd100, 32'd0, 32'd0, 48'd0}, 1'b0, '0};
    dir_table[4]  = '{'{MODE_STORE, 48'd100, P_MAX, P_MAX, 48'd0}, 1'b0, '0};
    dir_table[5]  = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, 48'd0}, 1'b1,
                      '{32'd0, P_MAX, 32'd0, P_MAX, 48'hFFFF_FFFF, 11'd2}};
    // window edge one short and exact
    dir_table[6]  = '{'{MODE_STORE, 48'd150, 32'd12345, 32'd10, 48'd0}, 1'b0, '0};
    dir_table[7]  = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, 48'd49}, 1'b0, '0};
    dir_table[8]  = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, 48'd50}, 1'b0, '0};
    // tick out of order
    dir_table[9]  = '{'{MODE_STORE, 48'd140, 32'd500, 32'd7, 48'd0}, 1'b0, '0};
    dir_table[10] = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, 48'd0}, 1'b0, '0};
    dir_table[11] = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, T_MAX}, 1'b0, '0};
    dir_table[12] = '{'{MODE_CLEAR, 48'd0, 32'd0, 32'd0, 48'd0}, 1'b0, '0};
    dir_table[13] = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, 48'd0}, 1'b1, '0};
    // timestamp extremes, window longer than newest time
    dir_table[14] = '{'{MODE_STORE, T_MAX, 32'd7, 32'd1, 48'd0}, 1'b0, '0};
    dir_table[15] = '{'{MODE_STORE, 48'd0, 32'd8, 32'd2, 48'd0}, 1'b0, '0};
    dir_table[16] = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, 48'd0}, 1'b0, '0};
    dir_table[17] = '{'{MODE_STORE, T_MAX, 32'd9, 32'd3, 48'd0}, 1'b0, '0};
    dir_table[18] = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, 48'd0}, 1'b0, '0};
    dir_table[19] = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, T_MAX}, 1'b0, '0};
    dir_table[20] = '{'{MODE_CLEAR, 48'd0, 32'd0, 32'd0, 48'd0}, 1'b0, '0};
    dir_table[21] = '{'{MODE_STORE, 48'd5, P_MAX, 32'd0, 48'd0}, 1'b0, '0};
    dir_table[22] = '{'{MODE_QUERY, 48'd0, 32'd0, 32'd0, 48'd1}, 1'b0, '0};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 27;
    recv_stall_pct = 76;
    for (int i = 0; i < N_DIR; i++)
      push_command(dir_table[i].cmd, dir_table[i].fixed, dir_table[i].bar);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 27;
          recv_stall_pct = 76;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 27;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (phase == 1) begin
        // long run of ticks so a query walks far back through the ring
        c = '0;
        c.mode = MODE_CLEAR;
        push_command(c, 1'b0, '0);
        for (int n = 0; n < FILL_RUN; n++) begin
          c.mode = MODE_STORE;
          last_time = last_time + TIME_W'($urandom_range(1, 20));
          c.tick_time = last_time;
          c.price = $urandom();
          c.volume = $urandom();
          push_command(c, 1'b0, '0);
        end
        for (int q = 0; q < 3; q++) begin
          c.mode = MODE_QUERY;
          if (q == 0) c.window = T_MAX;
          else if (q == 1) c.window = '0;
          else c.window = ring_time[back_slot(0)] - ring_time[back_slot(FILL_RUN / 2)];
          push_command(c, 1'b0, '0);
        end
        c.mode = MODE_CLEAR;
        push_command(c, 1'b0, '0);
      end

      taken = 0;
      while (taken < RAND_PER_PHASE) begin
        c = make_command();
        push_command(c, 1'b0, '0);
        if (c.mode != MODE_UNUSED) taken++;
      end
      // hold the sender until every bar is back
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
hw/rtl/tra_pkg.sv
hw/rtl/tra_front.sv
hw/rtl/tra_back.sv
hw/rtl/tick_ring_ohlcv_aggregator.sv
dv/tb_tick_ring_ohlcv_aggregator.sv
